FILE: hdl/mt_apparent_resistivity_phase_top_defines.svh
// Assertion macros shared by the project.
`ifndef MT_APPARENT_RESISTIVITY_PHASE_TOP_DEFINES_SVH
`define MT_APPARENT_RESISTIVITY_PHASE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MTAR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mtar_pkg.sv
package mtar_pkg;

  // Square root: operand bits, root bits and partial remainder bits.
  localparam int SQ_K  = 56;
  localparam int OP_W  = 2 * SQ_K;
  localparam int REM_W = SQ_K + 2;

  // Divider: divisor bits and quotient bits.
  localparam int D_W = 43;
  localparam int Q_W = 48;

  // Angle datapath.
  localparam int CW           = 60;
  localparam int ZW           = 30;
  localparam int CORDIC_STEPS = 24;

  localparam logic [Q_W-1:0] MAX48 = {Q_W{1'b1}};

  localparam logic signed [ZW-1:0] DEG180_Q20 = 30'sd188743680;
  localparam logic signed [ZW-1:0] DEG90_Q20  = 30'sd94371840;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 30'sd11796480;

  // Arctangent of 2^-i in degrees, Q.20.
  localparam logic signed [ZW-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
    30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
    30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
    30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7
  };

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [REM_W-1:0] rem;
    logic [SQ_K-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic              live;
    logic              errv;
    logic              agtm;
    logic [63:0]       m;
    logic [D_W-1:0]    d;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    sqrt_t             sp;
    sqrt_t             sy;
    sqrt_t             sx;
  } fe_t;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [Q_W-1:0] nq;
  } div_t;

  typedef struct packed {
    logic               spec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cor_t;

  typedef struct packed {
    logic           live;
    logic           errv;
    logic           agtm;
    logic           sat_r;
    logic           sat_e;
    logic [D_W-1:0] d;
    div_t           dr;
    div_t           de;
    cor_t           cp;
    cor_t           ce;
  } be_t;

  // One restoring square-root digit: two operand bits in, one root bit out.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sqrt_t r;
    t     = {s.rem, s.op[OP_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.op  = {s.op[OP_W-3:0], 2'b00};
    if (t >= trial) begin
      r.rem  = REM_W'(t - trial);
      r.root = {s.root[SQ_K-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(t);
      r.root = {s.root[SQ_K-2:0], 1'b0};
    end
    return r;
  endfunction

  // One restoring division step; quotient bits shift in behind the numerator.
  function automatic div_t div_step(div_t s, logic [D_W-1:0] d);
    logic [D_W:0] t;
    logic         ge;
    div_t         r;
    t     = {s.rem, s.nq[Q_W-1]};
    ge    = (t >= {1'b0, d});
    r.rem = ge ? D_W'(t - {1'b0, d}) : D_W'(t);
    r.nq  = {s.nq[Q_W-2:0], ge};
    return r;
  endfunction

  // Folds the left half plane and resolves the axis and zero cases.
  function automatic cor_t cordic_entry(logic signed [CW-1:0] x,
                                        logic signed [CW-1:0] y);
    cor_t c;
    logic signed [ZW-1:0] base;
    c.x  = x;
    c.y  = y;
    c.z  = '0;
    c.spec = 1'b0;
    base = '0;
    if (x == 0 && y == 0) begin
      c.spec = 1'b1;
    end else begin
      if (x < 0) begin
        base = (y >= 0) ? DEG180_Q20 : -DEG180_Q20;
        c.x  = -x;
        c.y  = -y;
      end
      if (c.y == 0) begin
        c.spec = 1'b1;
        c.z    = base;
      end else if (c.x == 0) begin
        c.spec = 1'b1;
        c.z    = (c.y > 0) ? DEG90_Q20 : -DEG90_Q20;
      end else begin
        c.z = base;
      end
    end
    return c;
  endfunction

  // Rounds Q.20 degrees to Q.16 and clamps to a half turn.
  function automatic logic signed [24:0] round_deg(logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = (z + 30'sd8) >>> 4;
    if (t > DEG180_Q16) begin
      t = DEG180_Q16;
    end else if (t < -DEG180_Q16) begin
      t = -DEG180_Q16;
    end
    return t[24:0];
  endfunction

endpackage

FILE: hdl/mtar_sqrt_cell.sv
module mtar_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  mtar_pkg::fe_t fe_i,
  output logic          vld_o,
  output mtar_pkg::fe_t fe_o
);
  import mtar_pkg::*;

  logic vld_r;
  fe_t  fe_r;
  fe_t  fe_nxt;

  // One root digit for each of the three square roots; the rest rides along.
  always_comb begin
    fe_nxt    = fe_i;
    fe_nxt.sp = sqrt_step(fe_i.sp);
    fe_nxt.sy = sqrt_step(fe_i.sy);
    fe_nxt.sx = sqrt_step(fe_i.sx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe_r <= fe_nxt;
    end
  end

  assign vld_o = vld_r;
  assign fe_o  = fe_r;

endmodule

FILE: hdl/mtar_be_cell.sv
module mtar_be_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  mtar_pkg::be_t be_i,
  output logic          vld_o,
  output mtar_pkg::be_t be_o
);
  import mtar_pkg::*;

  // Table entry for this cell; cells past the rotator never use it.
  localparam int AIDX = (STEP < CORDIC_STEPS) ? STEP : 0;

  logic vld_r;
  be_t  be_r;
  be_t  be_nxt;
  cor_t cp_nxt;
  cor_t ce_nxt;

  // One micro-rotation toward the x axis.
  function automatic cor_t rotate(cor_t c);
    cor_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    r  = c;
    dx = c.y >>> STEP;
    dy = c.x >>> STEP;
    if (!c.spec) begin
      if (c.y >= 0) begin
        r.x = c.x + dx;
        r.y = c.y - dy;
        r.z = c.z + ATAN_Q20[AIDX];
      end else begin
        r.x = c.x - dx;
        r.y = c.y + dy;
        r.z = c.z - ATAN_Q20[AIDX];
      end
    end
    return r;
  endfunction

  // Early cells also rotate; later cells only divide.
  generate
    if (STEP < CORDIC_STEPS) begin : g_rot
      always_comb begin
        cp_nxt = rotate(be_i.cp);
        ce_nxt = rotate(be_i.ce);
      end
    end else begin : g_hold
      always_comb begin
        cp_nxt = be_i.cp;
        ce_nxt = be_i.ce;
      end
    end
  endgenerate

  // One quotient bit for each of the two divisions.
  always_comb begin
    be_nxt    = be_i;
    be_nxt.dr = div_step(be_i.dr, be_i.d);
    be_nxt.de = div_step(be_i.de, be_i.d);
    be_nxt.cp = cp_nxt;
    be_nxt.ce = ce_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      be_r <= be_nxt;
    end
  end

  assign vld_o = vld_r;
  assign be_o  = be_r;

endmodule

FILE: hdl/mt_apparent_resistivity_phase_top.sv
// Depth: 111 register stages, from the input capture to the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result waits with out_tready low.
// The root cells (one digit each) and the divide cells (one quotient bit each)
// set the depth. Reset clears all valid bits; data registers are not reset.
module mt_apparent_resistivity_phase_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // z_real[31:0], z_imag[63:32], z_variance[95:64], frequency[135:96]
  input  logic [135:0] in_tdata,
  // has_impedance[0], has_variance[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // app_res[47:0], phase_deg[72:48], app_res_err[120:73],
  // phase_err_deg[144:121], zero fill[151:145]
  output logic [151:0] out_tdata,
  // saturated[0]
  output logic         out_tuser
);
  import mtar_pkg::*;
  `include "mt_apparent_resistivity_phase_top_defines.svh"

  logic en;
  logic out_vld_r;

  // Pipeline advance: move whenever the output register is free or drains.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage 1: capture and take magnitudes.
  logic               v1_r;
  logic               hz1_r, hv1_r;
  logic signed [31:0] zr1_r, zi1_r;
  logic [31:0]        ar1_r, ai1_r, var1_r;
  logic [39:0]        fq1_r;
  logic signed [31:0] zr_in, zi_in;

  assign zr_in = $signed(in_tdata[31:0]);
  assign zi_in = $signed(in_tdata[63:32]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hz1_r  <= in_tuser[0];
      hv1_r  <= in_tuser[1];
      zr1_r  <= zr_in;
      zi1_r  <= zi_in;
      ar1_r  <= zr_in[31] ? 32'(-zr_in) : 32'(zr_in);
      ai1_r  <= zi_in[31] ? 32'(-zi_in) : 32'(zi_in);
      var1_r <= in_tdata[95:64];
      fq1_r  <= in_tdata[135:96];
    end
  end

  // Stage 2: squares and divisor.
  logic               v2_r, live2_r, hv2_r;
  logic [63:0]        sqr2_r, sqi2_r;
  logic [D_W-1:0]     d2_r;
  logic signed [31:0] zr2_r, zi2_r;
  logic [31:0]        var2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqr2_r  <= 64'(ar1_r) * 64'(ar1_r);
      sqi2_r  <= 64'(ai1_r) * 64'(ai1_r);
      d2_r    <= D_W'({3'b000, fq1_r}) + D_W'({1'b0, fq1_r, 2'b00});
      live2_r <= hz1_r && (fq1_r != '0);
      hv2_r   <= hv1_r;
      zr2_r   <= zr1_r;
      zi2_r   <= zi1_r;
      var2_r  <= var1_r;
    end
  end

  // Stage 3: squared magnitude.
  logic               v3_r, live3_r, hv3_r;
  logic [63:0]        m3_r;
  logic [D_W-1:0]     d3_r;
  logic signed [31:0] zr3_r, zi3_r;
  logic [31:0]        var3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r    <= sqr2_r + sqi2_r;
      d3_r    <= d2_r;
      live3_r <= live2_r;
      hv3_r   <= hv2_r;
      zr3_r   <= zr2_r;
      zi3_r   <= zi2_r;
      var3_r  <= var2_r;
    end
  end

  // Stage 4: magnitude times variance in two halves, ratio check.
  logic               v4_r, live4_r, errv4_r, agtm4_r;
  logic [63:0]        pv04_r, pv14_r, m4_r, mma4_r;
  logic [D_W-1:0]     d4_r;
  logic signed [31:0] zr4_r, zi4_r;
  logic [31:0]        var4_r;
  logic [63:0]        a3;

  assign a3 = {16'h0000, var3_r, 16'h0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv04_r  <= 64'(m3_r[31:0]) * 64'(var3_r);
      pv14_r  <= 64'(m3_r[63:32]) * 64'(var3_r);
      agtm4_r <= a3 > m3_r;
      mma4_r  <= m3_r - a3;
      errv4_r <= hv3_r && (m3_r != '0);
      m4_r    <= m3_r;
      d4_r    <= d3_r;
      live4_r <= live3_r;
      zr4_r   <= zr3_r;
      zi4_r   <= zi3_r;
      var4_r  <= var3_r;
    end
  end

  // Stage 5: load the three root operands.
  fe_t         fe_pipe [SQ_K+1];
  logic        fe_vld  [SQ_K+1];
  fe_t         fe_nxt;
  logic [95:0] prod4;
  fe_t         fe0_r;
  logic        fe0_vld_r;

  assign prod4 = {pv14_r, 32'h0000_0000} + {32'h0000_0000, pv04_r};

  always_comb begin
    fe_nxt.live    = live4_r;
    fe_nxt.errv    = errv4_r;
    fe_nxt.agtm    = agtm4_r;
    fe_nxt.m       = m4_r;
    fe_nxt.d       = d4_r;
    fe_nxt.zr      = zr4_r;
    fe_nxt.zi      = zi4_r;
    fe_nxt.sp.op   = {prod4, 16'h0000};
    fe_nxt.sp.rem  = '0;
    fe_nxt.sp.root = '0;
    fe_nxt.sy.op   = {16'h0000, var4_r, 64'h0};
    fe_nxt.sy.rem  = '0;
    fe_nxt.sy.root = '0;
    fe_nxt.sx.op   = {mma4_r, 48'h0};
    fe_nxt.sx.rem  = '0;
    fe_nxt.sx.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe0_vld_r <= 1'b0;
    end else if (en) begin
      fe0_vld_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe0_r <= fe_nxt;
    end
  end

  assign fe_pipe[0] = fe0_r;
  assign fe_vld[0]  = fe0_vld_r;

  // Square-root cells, one digit each.
  generate
    for (genvar g = 0; g < SQ_K; g++) begin : g_sqrt
      mtar_sqrt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (fe_vld[g]),
        .fe_i  (fe_pipe[g]),
        .vld_o (fe_vld[g+1]),
        .fe_o  (fe_pipe[g+1])
      );
    end
  endgenerate

  // Entry stage: saturation checks, divider and rotator start values.
  fe_t       fl;
  be_t       be_nxt;
  be_t       be0_r;
  logic      be0_vld_r;
  be_t       be_pipe [Q_W+1];
  logic      be_vld  [Q_W+1];

  assign fl = fe_pipe[SQ_K];

  always_comb begin
    be_nxt.live   = fl.live;
    be_nxt.errv   = fl.errv;
    be_nxt.agtm   = fl.agtm;
    be_nxt.d      = fl.d;
    be_nxt.sat_r  = {19'h0, fl.m[63:40]} >= fl.d;
    be_nxt.dr.rem = D_W'(fl.m[63:40]);
    be_nxt.dr.nq  = {fl.m[39:0], 8'h00};
    be_nxt.sat_e  = {26'h0, fl.sp.root[55:39]} >= fl.d;
    be_nxt.de.rem = D_W'(fl.sp.root[55:39]);
    be_nxt.de.nq  = {fl.sp.root[38:0], 9'h000};
    be_nxt.cp     = cordic_entry(CW'($signed({fl.zr, 24'h0})),
                                 CW'($signed({fl.zi, 24'h0})));
    be_nxt.ce     = cordic_entry($signed({4'h0, fl.sx.root}),
                                 $signed({4'h0, fl.sy.root}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be0_vld_r <= 1'b0;
    end else if (en) begin
      be0_vld_r <= fe_vld[SQ_K];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      be0_r <= be_nxt;
    end
  end

  assign be_pipe[0] = be0_r;
  assign be_vld[0]  = be0_vld_r;

  // Divide and rotate cells.
  generate
    for (genvar g = 0; g < Q_W; g++) begin : g_be
      mtar_be_cell #(.STEP(g)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (be_vld[g]),
        .be_i  (be_pipe[g]),
        .vld_o (be_vld[g+1]),
        .be_o  (be_pipe[g+1])
      );
    end
  endgenerate

  // Output register: select, round and zero the results.
  be_t                bl;
  logic [Q_W-1:0]     res_r, res_nxt, rerr_r, rerr_nxt;
  logic signed [24:0] ph_r, ph_nxt, pe_full;
  logic [23:0]        perr_r, perr_nxt;
  logic               sat_r, sat_nxt;

  assign bl = be_pipe[Q_W];

  always_comb begin
    pe_full  = round_deg(bl.ce.z);
    res_nxt  = '0;
    rerr_nxt = '0;
    ph_nxt   = '0;
    perr_nxt = '0;
    sat_nxt  = 1'b0;
    if (bl.live) begin
      res_nxt = bl.sat_r ? MAX48 : bl.dr.nq;
      ph_nxt  = round_deg(bl.cp.z);
      sat_nxt = bl.sat_r;
      if (bl.errv) begin
        rerr_nxt = bl.sat_e ? MAX48 : bl.de.nq;
        sat_nxt  = bl.sat_r || bl.sat_e;
        if (bl.agtm) begin
          perr_nxt = DEG180_Q16[23:0];
        end else if (pe_full < 0) begin
          perr_nxt = '0;
        end else begin
          perr_nxt = pe_full[23:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= be_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      rerr_r <= rerr_nxt;
      ph_r   <= ph_nxt;
      perr_r <= perr_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'h00, perr_r, rerr_r, ph_r, res_r};
  assign out_tuser  = sat_r;

  // Checks on the result datapath and the pipeline advance.
  `MTAR_ASSERT_IMPL(a_sat_max, out_vld_r && sat_r, res_r == MAX48 || rerr_r == MAX48, "saturated without a clipped resistivity")
  `MTAR_ASSERT_IMPL(a_perr_range, out_vld_r, perr_r <= DEG180_Q16[23:0], "phase error beyond half turn")
  `MTAR_ASSERT_IMPL(a_ph_range, out_vld_r, ph_r <= 25'sd11796480 && ph_r >= -25'sd11796480, "phase beyond half turn")
  `MTAR_ASSERT_NEXT(a_entry_adv, be0_vld_r && en, be_vld[1], "entry item lost in first divide cell")

endmodule

FILE: test/mt_apparent_resistivity_phase_top_tb.sv
module mt_apparent_resistivity_phase_top_tb;
  import mtar_pkg::*;

  localparam int  RANDOM_ITEMS = 650;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  DRAIN_CYCLES = 130;

  // One expected result as the block packs it.
  typedef struct {
    logic [47:0] app_res;
    logic [24:0] phase_deg;
    logic [47:0] app_res_err;
    logic [23:0] phase_err_deg;
    logic        saturated;
  } mt_result_t;

  // Predicts results from accepted requests and compares them in order.
  class mt_scoreboard;
    mt_result_t pending[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Floor square root of a wide operand, one root bit per pass.
    function logic [127:0] floor_sqrt(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] bitv;
      root = '0;
      bitv = 128'd1 << 126;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n    = n - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // Quotient clipped to 48 bits; a clip raises the flag.
    function logic [47:0] clip_div(logic [127:0] num, logic [127:0] den, ref logic sat);
      logic [127:0] q;
      q = num / den;
      if (q > {80'd0, MAX48}) begin
        sat = 1'b1;
        return MAX48;
      end
      return q[47:0];
    endfunction

    // Vectoring CORDIC angle in Q.16 degrees, clamped to a half turn.
    function longint cordic_deg(longint x, longint y);
      longint base, z, dx, dy;
      base = 0;
      z    = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        base = (y >= 0) ? 64'sd188743680 : -64'sd188743680;
        x = -x;
        y = -y;
      end
      if (y == 0) begin
        z = base;
      end else if (x == 0) begin
        z = (y > 0) ? 64'sd94371840 : -64'sd94371840;
      end else begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_Q20[i]);
          end else begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_Q20[i]);
          end
        end
        z = z + base;
      end
      z = (z + 8) >>> 4;
      if (z > longint'(DEG180_Q16)) z = longint'(DEG180_Q16);
      if (z < -longint'(DEG180_Q16)) z = -longint'(DEG180_Q16);
      return z;
    endfunction

    // Works out the result of one accepted request.
    function void note_request(logic [135:0] td, logic [1:0] tu);
      mt_result_t   r;
      longint       zr, zi, ph, pe;
      logic [63:0]  ar, ai, m, a;
      logic [127:0] d, s, ys, xs;
      logic [31:0]  var_q;
      logic [39:0]  freq;
      zr    = longint'($signed(td[31:0]));
      zi    = longint'($signed(td[63:32]));
      var_q = td[95:64];
      freq  = td[135:96];
      r.app_res = '0; r.phase_deg = '0; r.app_res_err = '0;
      r.phase_err_deg = '0; r.saturated = 1'b0;
      if (tu[0] && freq != 0) begin
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        m  = ar * ar + ai * ai;
        d  = 128'(freq) * 5;
        r.app_res   = clip_div(128'(m) << 8, d, r.saturated);
        ph          = cordic_deg(zr * 16777216, zi * 16777216);
        r.phase_deg = ph[24:0];
        if (tu[1] && m != 0) begin
          s = floor_sqrt((128'(m) * 128'(var_q)) << 16);
          r.app_res_err = clip_div(s << 9, d, r.saturated);
          a = 64'(var_q) << 16;
          if (a > m) begin
            r.phase_err_deg = DEG180_Q16[23:0];
          end else begin
            ys = floor_sqrt(128'(a) << 48);
            xs = floor_sqrt(128'(m - a) << 48);
            pe = cordic_deg(longint'(xs), longint'(ys));
            if (pe < 0) pe = 0;
            r.phase_err_deg = pe[23:0];
          end
        end
      end
      pending = {pending, r};
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic [151:0] td, logic tu);
      mt_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected: data %h sat %b", $realtime, td, tu);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (td[47:0] !== e.app_res) begin
        $display("%0t: app_res expected %h actual %h", $realtime, e.app_res, td[47:0]);
        errors++;
      end
      if (td[72:48] !== e.phase_deg) begin
        $display("%0t: phase_deg expected %h actual %h", $realtime, e.phase_deg, td[72:48]);
        errors++;
      end
      if (td[120:73] !== e.app_res_err) begin
        $display("%0t: app_res_err expected %h actual %h", $realtime, e.app_res_err,
                 td[120:73]);
        errors++;
      end
      if (td[144:121] !== e.phase_err_deg) begin
        $display("%0t: phase_err_deg expected %h actual %h", $realtime, e.phase_err_deg,
                 td[144:121]);
        errors++;
      end
      if (td[151:145] !== 7'd0) begin
        $display("%0t: zero fill expected 0 actual %h", $realtime, td[151:145]);
        errors++;
      end
      if (tu !== e.saturated) begin
        $display("%0t: saturated expected %b actual %b", $realtime, e.saturated, tu);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;
  logic         out_tuser;

  mt_scoreboard sb;
  int           cycles;
  bit           no_idle;

  mt_apparent_resistivity_phase_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels and the cycle budget at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (cycles > CYCLE_LIMIT) begin
      $display("mt_apparent_resistivity_phase_top verification failed");
      $finish;
    end
  end

  // Result side: a random stall before each result, none in quiet stretches.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Sends one request after a random gap and holds it until accepted.
  task automatic send_request(logic hz, logic signed [31:0] zr, logic signed [31:0] zi,
                              logic hv, logic [31:0] var_q, logic [39:0] freq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {freq, var_q, zi, zr};
    in_tuser  = {hv, hz};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Random request, mostly well-formed values of useful scale.
  task automatic send_random();
    logic signed [31:0] zr, zi;
    logic [31:0]        var_q;
    logic [39:0]        freq;
    logic [63:0]        m;
    int                 k;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      zr = $urandom;
      zi = $urandom;
    end else begin
      zr = $signed($urandom) >>> $urandom_range(0, 31);
      zi = $signed($urandom) >>> $urandom_range(0, 31);
    end
    case ($urandom_range(0, 5))
      0:       freq = {8'($urandom_range(0, 255)), 32'($urandom)};
      1:       freq = 40'($urandom_range(0, 3));
      2:       freq = 40'(1) << $urandom_range(0, 39);
      default: freq = {8'd0, $urandom} >> $urandom_range(0, 20) | 40'd1 << 24;
    endcase
    m = 64'($signed(zr) * $signed(zr)) + 64'($signed(zi) * $signed(zi));
    case ($urandom_range(0, 3))
      0:       var_q = $urandom;
      1:       var_q = $urandom >> $urandom_range(0, 31);
      default: var_q = 32'((m >> 16) >> $urandom_range(0, 12));
    endcase
    send_request($urandom_range(0, 15) != 0, zr, zi, $urandom_range(0, 5) != 0, var_q, freq);
  endtask

  // Stimulus.
  initial begin
    int wait_cycles;
    sb         = new();
    cycles     = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed cases: absent impedance, zero frequency, zero vector, axes,
    // extremes, saturation and a ratio above one.
    send_request(1'b0, 32'sh10000, 32'sh10000, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, 32'sh10000, 32'sh10000, 1'b1, 32'h100, 40'd0);
    send_request(1'b1, 32'sd0, 32'sd0, 1'b1, 32'h10000, 40'h1000000);
    send_request(1'b1, 32'sd0, 32'sd0, 1'b0, 32'd0, 40'hFFFFFFFFFF);
    send_request(1'b1, 32'sh10000, 32'sd0, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, -32'sh10000, 32'sd0, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, 32'sd0, 32'sh10000, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, 32'sd0, -32'sh10000, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, -32'sh10000, -32'sh1, 1'b1, 32'h100, 40'h1000000);
    send_request(1'b1, 32'sh80000000, 32'sh80000000, 1'b1, 32'hFFFFFFFF, 40'd1);
    send_request(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 32'hFFFFFFFF, 40'hFFFFFFFFFF);
    send_request(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 32'h1, 40'd1);
    send_request(1'b1, 32'sh10000, 32'sh0, 1'b1, 32'h20000, 40'h1000000);
    send_request(1'b1, 32'sh10000, 32'sh0, 1'b1, 32'h10000, 40'h1000000);
    send_request(1'b1, 32'sh30000, -32'sh40000, 1'b1, 32'h10000, 40'h1000000);
    send_request(1'b1, 32'sh30000, -32'sh40000, 1'b0, 32'h10000, 40'h1000000);
    send_request(1'b1, 32'sd1, 32'sd1, 1'b1, 32'd0, 40'hFFFFFFFFFF);
    send_request(1'b1, -32'sd1, 32'sd1, 1'b1, 32'd1, 40'd1);
    send_request(1'b1, -32'sh123456, 32'sh654321, 1'b1, 32'h5555, 40'h0AAAAAAAAA);

    // Random part, with quiet stretches where neither side idles.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = $urandom_range(0, 2) == 0;
      send_random();
    end
    in_tvalid = 1'b0;
    no_idle   = 1'b0;

    // Drain, then let the pipeline settle.
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("mt_apparent_resistivity_phase_top verification clean");
    end else begin
      $display("mt_apparent_resistivity_phase_top verification failed");
    end
    $finish;
  end

endmodule

FILE: mt_apparent_resistivity_phase_top.f
+incdir+hdl
hdl/mtar_pkg.sv
hdl/mtar_sqrt_cell.sv
hdl/mtar_be_cell.sv
hdl/mt_apparent_resistivity_phase_top.sv
test/mt_apparent_resistivity_phase_top_tb.sv
